@@ hdl/draw_call_batcher_assert.svh @@
// Assertion macros of the draw call batcher, used by dcb_ctrl.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef DRAW_CALL_BATCHER_ASSERT_SVH
`define DRAW_CALL_BATCHER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define DCB_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("dcb check failed");

// Check that a condition implies another in the next cycle.
`define DCB_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("dcb check failed");

`endif

@@ hdl/dcb_pkg.sv @@
// Shared types and constants of the draw call batcher.
// Depends on nothing; used by dcb_ctrl, dcb_datapath and draw_call_batcher.
package dcb_pkg;

    localparam int TEXTURE_SLOTS = 8;
    localparam int SLOT_IW       = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
    localparam int CNT_W         = $clog2(TEXTURE_SLOTS + 1);

    typedef struct packed {
        logic        pass_start;
        logic [15:0] shader_id;
        logic [3:0]  blend_mode;
        logic [31:0] texture_id;
        logic [31:0] base_index;
        logic [31:0] index_count;
    } t_submit;

    typedef struct packed {
        logic [2:0]  texture_slot;
        logic        new_batch;
        logic [31:0] batch_offset;
        logic [31:0] batch_count;
        logic [3:0]  slots_used;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } t_cmd;

endpackage

@@ hdl/draw_call_batcher.sv @@
// Draw call batcher: one result per submit; a submit passes a slot compare state, then a batch
// update state that waits for the output register to be free, then the result register;
// a new submit is taken in the update state while the output register is free.
// Reset (i_rst_n low, synchronous) closes the open batch and empties the output;
// the slot table is not cleared, entries past the fill count are never read.
// Depends on dcb_pkg, dcb_ctrl and dcb_datapath.
module draw_call_batcher (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dcb_pkg::t_submit i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output dcb_pkg::t_result o_out_item
);

    dcb_pkg::t_cmd w_cmd;

    dcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    dcb_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_in_item),
        .o_item  (o_out_item)
    );

endmodule

@@ hdl/dcb_ctrl.sv @@
// Controller of the draw call batcher: sequences load, compare and update.
// Depends on dcb_pkg and draw_call_batcher_assert.svh.
`include "draw_call_batcher_assert.svh"

module dcb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dcb_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_upd_go;
    logic   w_accept;

    // Update may fire only when the output register is empty or being taken
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_upd_go   = (r_state == S_UPD) && w_out_free;
    assign o_in_ready = (r_state == S_IDLE) || w_upd_go;
    assign w_accept   = i_in_valid && o_in_ready;

    assign o_cmd.load    = w_accept;
    assign o_cmd.compare = (r_state == S_CMP);
    assign o_cmd.update  = w_upd_go;
    assign o_out_valid   = r_out_valid;

    // Advance the sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end else if (w_upd_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until the item is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_upd_go) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `DCB_ASSERT_NEXT(a_accept_to_cmp, i_clk, i_rst_n, w_accept, r_state == S_CMP)
    `DCB_ASSERT_NEXT(a_cmp_to_upd, i_clk, i_rst_n, r_state == S_CMP, r_state == S_UPD)
    `DCB_ASSERT_NEXT(a_update_shows, i_clk, i_rst_n, w_upd_go, r_out_valid)
    `DCB_ASSERT_SAME(a_no_load_in_cmp, i_clk, i_rst_n, r_state == S_CMP, !o_in_ready)

endmodule

@@ hdl/dcb_datapath.sv @@
// Datapath of the draw call batcher: open batch state, texture slot table,
// slot compare and batch update. Depends on dcb_pkg.
module dcb_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dcb_pkg::t_cmd    i_cmd,
    input  dcb_pkg::t_submit i_item,
    output dcb_pkg::t_result o_item
);

    dcb_pkg::t_submit r_in;
    dcb_pkg::t_result r_out, n_out;

    logic                      r_batch_open;
    logic [15:0]               r_open_shader;
    logic [3:0]                r_open_blend;
    logic [31:0]               r_open_offset, n_open_offset;
    logic [31:0]               r_open_count, n_open_count;
    logic [dcb_pkg::CNT_W-1:0] r_filled, n_filled;
    logic [31:0]               r_slot_tex [dcb_pkg::TEXTURE_SLOTS];

    logic [dcb_pkg::TEXTURE_SLOTS-1:0] r_match, n_match;
    logic                              r_same, n_same;

    logic                        w_found;
    logic [dcb_pkg::SLOT_IW-1:0] w_match_idx;
    logic                        w_room;
    logic                        w_open_new;
    logic                        w_place;
    logic [31:0]                 w_base_count;
    logic [32:0]                 w_sum;
    logic [dcb_pkg::CNT_W-1:0]   w_base_filled;
    logic [dcb_pkg::SLOT_IW-1:0] w_slot_idx;
    logic [31:0]                 w_slot_wide;
    logic [31:0]                 w_fill_wide;

    // Capture the submit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
    end

    // Compare the texture against every filled slot in parallel
    always_comb begin
        for (int i = 0; i < dcb_pkg::TEXTURE_SLOTS; i++) begin
            n_match[i] = (dcb_pkg::CNT_W'(i) < r_filled) && (r_slot_tex[i] == r_in.texture_id);
        end
        n_same = r_batch_open && !r_in.pass_start &&
                 (r_in.shader_id == r_open_shader) && (r_in.blend_mode == r_open_blend);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_match <= n_match;
            r_same  <= n_same;
        end
    end

    // Pick the lowest matching slot
    always_comb begin
        w_match_idx = '0;
        for (int i = dcb_pkg::TEXTURE_SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_match_idx = dcb_pkg::SLOT_IW'(i);
            end
        end
    end

    // Decide the batch and compute the new state
    always_comb begin
        w_found       = |r_match;
        w_room        = r_filled < dcb_pkg::CNT_W'(dcb_pkg::TEXTURE_SLOTS);
        w_open_new    = !r_same || (!w_found && !w_room);
        w_base_count  = w_open_new ? 32'd0 : r_open_count;
        w_base_filled = w_open_new ? '0 : r_filled;
        w_sum         = {1'b0, w_base_count} + {1'b0, r_in.index_count};
        n_open_count  = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
        n_open_offset = w_open_new ? r_in.base_index : r_open_offset;
        // A new batch always places; otherwise place only on a miss
        w_place       = w_open_new || !w_found;
        w_slot_idx    = w_place ? w_base_filled[dcb_pkg::SLOT_IW-1:0] : w_match_idx;
        n_filled      = w_place ? w_base_filled + dcb_pkg::CNT_W'(1) : w_base_filled;
        w_slot_wide   = 32'(w_slot_idx);
        w_fill_wide   = 32'(n_filled);

        n_out.texture_slot = w_slot_wide[2:0];
        n_out.new_batch    = w_open_new;
        n_out.batch_offset = n_open_offset;
        n_out.batch_count  = n_open_count;
        n_out.slots_used   = w_fill_wide[3:0];
    end

    // Commit the batch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_open  <= 1'b0;
            r_open_shader <= '0;
            r_open_blend  <= '0;
            r_open_offset <= '0;
            r_open_count  <= '0;
            r_filled      <= '0;
        end else if (i_cmd.update) begin
            r_batch_open  <= 1'b1;
            r_open_shader <= r_in.shader_id;
            r_open_blend  <= r_in.blend_mode;
            r_open_offset <= n_open_offset;
            r_open_count  <= n_open_count;
            r_filled      <= n_filled;
        end
    end

    // Write the slot table and the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (w_place) begin
                r_slot_tex[w_slot_idx] <= r_in.texture_id;
            end
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of draw_call_batcher: batch grouping, texture slots, count saturation.
// A queue-fed driver and a clocked monitor compare every result with an in-bench batch predictor.
// Depends on dcb_pkg and draw_call_batcher.
module tb_top;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int QUIET_TAIL   = 150;
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 1370;
    localparam int DRAIN_INDEX  = 700;

    typedef struct {
        dcb_pkg::t_submit item;
        bit               drain_first;
    } t_pending_submit;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    dcb_pkg::t_submit in_item  = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    dcb_pkg::t_result out_item;

    t_pending_submit  pending_submits[$];
    dcb_pkg::t_result expected_results[$];
    int               gap_left      = 0;
    int               stall_left    = 0;
    int               idle_cycles   = 0;
    int               mismatch_count = 0;

    // Batch state tracked by the predictor
    logic        batch_open   = 1'b0;
    logic [15:0] open_shader  = '0;
    logic [3:0]  open_blend   = '0;
    logic [31:0] open_offset  = '0;
    logic [31:0] open_count   = '0;
    int          filled_slots = 0;
    logic [31:0] slot_tex [dcb_pkg::TEXTURE_SLOTS];

    draw_call_batcher i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // Return the lowest filled slot holding tex, or the fill count if absent
    function automatic int lookup_slot(input logic [31:0] tex);
        int i;
        for (i = 0; i < filled_slots && i < dcb_pkg::TEXTURE_SLOTS; i++) begin
            if (slot_tex[i] == tex) begin
                return i;
            end
        end
        return filled_slots;
    endfunction

    // Advance the batch state by one submit and return the result it gives
    function automatic dcb_pkg::t_result predict_batch(input dcb_pkg::t_submit s);
        dcb_pkg::t_result r;
        logic             open_new;
        int               slot;
        logic [32:0]      sum;
        if (s.pass_start || !batch_open) begin
            open_new = 1'b1;
        end else begin
            slot = lookup_slot(s.texture_id);
            open_new = (s.shader_id != open_shader) || (s.blend_mode != open_blend) ||
                       (slot >= filled_slots && filled_slots >= dcb_pkg::TEXTURE_SLOTS);
        end
        if (open_new) begin
            batch_open   = 1'b1;
            open_shader  = s.shader_id;
            open_blend   = s.blend_mode;
            open_offset  = s.base_index;
            open_count   = '0;
            filled_slots = 0;
        end
        // Saturate the running count
        sum = {1'b0, open_count} + {1'b0, s.index_count};
        open_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        slot = lookup_slot(s.texture_id);
        if (slot >= filled_slots && filled_slots < dcb_pkg::TEXTURE_SLOTS) begin
            slot_tex[filled_slots] = s.texture_id;
            filled_slots++;
        end
        r.texture_slot = slot[2:0];
        r.new_batch    = open_new;
        r.batch_offset = open_offset;
        r.batch_count  = open_count;
        r.slots_used   = filled_slots[3:0];
        return r;
    endfunction

    task automatic queue_submit(input logic ps, input logic [15:0] sh, input logic [3:0] bl,
                                input logic [31:0] tex, input logic [31:0] base,
                                input logic [31:0] cnt);
        t_pending_submit p;
        p.item.pass_start  = ps;
        p.item.shader_id   = sh;
        p.item.blend_mode  = bl;
        p.item.texture_id  = tex;
        p.item.base_index  = base;
        p.item.index_count = cnt;
        p.drain_first      = 1'b0;
        pending_submits.insert(pending_submits.size(), p);
    endtask

    task automatic report_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Driver: hold an item until accepted, then load the next one or idle
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.insert(expected_results.size(), predict_batch(in_item));
            end
            if (in_valid && !in_ready) begin
                in_valid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_submits.size() == 0 ||
                         (pending_submits[0].drain_first && expected_results.size() != 0)) begin
                in_valid <= 1'b0;
            end else if (pending_submits.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
                gap_left <= $urandom_range(0, 17);
                in_valid <= 1'b0;
            end else begin
                in_item  <= pending_submits[0].item;
                in_valid <= 1'b1;
                pending_submits.pop_front();
            end
        end
    end

    // Monitor: check each accepted result, stall the output in bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, expected none, actual %p",
                             $time, out_item);
                    mismatch_count++;
                end else begin
                    report_field("texture_slot", expected_results[0].texture_slot,
                                 out_item.texture_slot);
                    report_field("new_batch", expected_results[0].new_batch,
                                 out_item.new_batch);
                    report_field("batch_offset", expected_results[0].batch_offset,
                                 out_item.batch_offset);
                    report_field("batch_count", expected_results[0].batch_count,
                                 out_item.batch_count);
                    report_field("slots_used", expected_results[0].slots_used,
                                 out_item.slots_used);
                    expected_results.pop_front();
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end else if (pending_submits.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 17);
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] shader;
        logic [3:0]  blend;
        logic [31:0] base;
        logic [31:0] cnt;
        logic [31:0] tex_pool [12];
        int          pool_size;
        int          run_len;
        int          pick;
        int          i;
        int          j;

        // First submit after reset opens a batch without pass start
        queue_submit(1'b0, 16'h0000, 4'h0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        // Fill every slot of the batch
        for (i = 1; i < dcb_pkg::TEXTURE_SLOTS; i++) begin
            queue_submit(1'b0, 16'h0000, 4'h0, i, $urandom, i * 16);
        end
        // Known texture with a full table stays in the batch
        queue_submit(1'b0, 16'h0000, 4'h0, 32'h0000_0003, 32'h1234_5678, 32'h0000_0001);
        // New texture with a full table opens a batch; counts run into saturation
        queue_submit(1'b0, 16'h0000, 4'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_submit(1'b0, 16'h0000, 4'h0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
        queue_submit(1'b0, 16'h0000, 4'h0, 32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFF);
        // Shader change, blend change, then pass start with nothing changed
        queue_submit(1'b0, 16'hFFFF, 4'h0, 32'h0000_0005, 32'hAAAA_AAAA, 32'h0000_0010);
        queue_submit(1'b0, 16'hFFFF, 4'hF, 32'h0000_0005, 32'h5555_5555, 32'h0000_0020);
        queue_submit(1'b1, 16'hFFFF, 4'hF, 32'h0000_0005, 32'h0F0F_0F0F, 32'hFFFF_FFF0);
        queue_submit(1'b0, 16'hFFFF, 4'hF, 32'hAAAA_5555, 32'h0000_0000, 32'h5555_AAAA);
        queue_submit(1'b1, 16'h5A5A, 4'h5, 32'h5555_AAAA, 32'hF0F0_F0F0, 32'h0000_0000);
        // Hold the sender before the last directed submit until all earlier results are in
        pending_submits[pending_submits.size() - 1].drain_first = 1'b1;

        // Random batches with shared shader, blend and a small texture pool; some noise
        shader = $urandom;
        while (pending_submits.size() < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_submit($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                             $urandom);
            end else begin
                if ($urandom_range(0, 3) != 0) begin
                    shader = $urandom;
                end
                blend     = $urandom_range(0, 15);
                base      = $urandom;
                pool_size = $urandom_range(1, 12);
                for (i = 0; i < pool_size; i++) begin
                    tex_pool[i] = $urandom;
                end
                run_len = $urandom_range(1, 16);
                for (j = 0; j < run_len; j++) begin
                    pick = $urandom_range(0, 31);
                    if (pick == 0) begin
                        cnt = $urandom;
                    end else if (pick == 1) begin
                        cnt = 32'hFFFF_FFFF - $urandom_range(0, 255);
                    end else begin
                        cnt = $urandom_range(0, 4096);
                    end
                    queue_submit((j == 0) ? ($urandom_range(0, 3) != 0)
                                          : ($urandom_range(0, 40) == 0),
                                 shader,
                                 ($urandom_range(0, 24) == 0) ? $urandom_range(0, 15) : blend,
                                 tex_pool[$urandom_range(0, pool_size - 1)],
                                 $urandom, cnt);
                end
            end
        end
        pending_submits[DRAIN_INDEX].drain_first = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to go in and every result to come out
        @(posedge clk);
        while (pending_submits.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
